>>> rtl/core/lcfp_pkg.sv
// Shared types, codes and defaults for the LED command frame parser.
package lcfp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0] SYNC_RESET   = 8'hAA;
   localparam logic [7:0] HEADER_RESET = 8'hBB;

   localparam logic REG_SYNC   = 1'b0;
   localparam logic REG_HEADER = 1'b1;

   localparam logic [7:0] CMD_LED   = 8'h01;
   localparam logic [7:0] CMD_BLINK = 8'h02;
   localparam logic [7:0] CMD_QUERY = 8'h03;

   localparam logic [7:0] REPLY_TAG  = 8'h01;
   localparam logic [7:0] STATUS_OK  = 8'h10;
   localparam logic [7:0] STATUS_ERR = 8'h20;

   localparam logic [7:0] LEN_LED   = 8'h02;
   localparam logic [7:0] LEN_OTHER = 8'h01;
   localparam logic [7:0] DATA_ZERO = 8'h00;
   localparam logic [7:0] DATA_ONE  = 8'h01;

   localparam logic [1:0] LED_OFF   = 2'd0;
   localparam logic [1:0] LED_ON    = 2'd1;
   localparam logic [1:0] LED_FLASH = 2'd2;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_SYNC  = 3'd1;
   localparam logic [2:0] ERR_CMD   = 3'd2;
   localparam logic [2:0] ERR_LEN   = 3'd3;
   localparam logic [2:0] ERR_DATA1 = 3'd4;
   localparam logic [2:0] ERR_DATA2 = 3'd5;

   localparam logic [1:0] IDX_HEADER = 2'd0;
   localparam logic [1:0] IDX_CMD    = 2'd1;
   localparam logic [1:0] IDX_TAG    = 2'd2;
   localparam logic [1:0] IDX_STATUS = 2'd3;

   typedef struct packed {
      logic [7:0] command;
      logic [1:0] led_mode;
      logic [2:0] error_kind;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic    empty;
      job_type job;
   } job_head_type;

endpackage

>>> rtl/core/lcfp_csr.sv
// Configuration registers: sync byte and reply header, APB-style access.
module lcfp_csr #(
   parameter int ADDR_W = lcfp_pkg::CSR_ADDR_W,
   parameter int DATA_W = lcfp_pkg::CSR_DATA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output logic [7:0]        sync_value,
   output logic [7:0]        reply_header
);

   logic [7:0] sync_ff, sync_in;
   logic [7:0] header_ff, header_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      sync_in   = sync_ff;
      header_in = header_ff;
      if (wr_en) begin
         unique case (reg_sel)
            lcfp_pkg::REG_SYNC:   sync_in   = csr_pwdata[7:0];
            lcfp_pkg::REG_HEADER: header_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= lcfp_pkg::SYNC_RESET;
         header_ff <= lcfp_pkg::HEADER_RESET;
      end else begin
         sync_ff   <= sync_in;
         header_ff <= header_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         lcfp_pkg::REG_SYNC:   csr_prdata[7:0] = sync_ff;
         lcfp_pkg::REG_HEADER: csr_prdata[7:0] = header_ff;
         default: ;
      endcase
   end

   assign sync_value   = sync_ff;
   assign reply_header = header_ff;

endmodule

>>> rtl/core/lcfp_front.sv
// Frame parser: checks each received byte and queues a reply job when one is due.
module lcfp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             sync_value,
   output lcfp_pkg::job_push_type push
);

   typedef enum logic [4:0] {
      ST_SYNC  = 5'b00001,
      ST_CMD   = 5'b00010,
      ST_LEN   = 5'b00100,
      ST_DATA1 = 5'b01000,
      ST_DATA2 = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [1:0] led_ff, led_in;
   logic       emit;
   logic [2:0] err;
   logic [7:0] job_cmd;
   logic       is_led;

   assign is_led = (cmd_ff == lcfp_pkg::CMD_LED);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      led_in   = led_ff;
      emit     = 1'b0;
      err      = lcfp_pkg::ERR_NONE;
      job_cmd  = cmd_ff;
      unique case (state_ff)
         ST_CMD: begin
            cmd_in  = rx_byte;
            job_cmd = rx_byte;
            if (rx_byte != lcfp_pkg::CMD_LED && rx_byte != lcfp_pkg::CMD_BLINK &&
                rx_byte != lcfp_pkg::CMD_QUERY) begin
               emit = 1'b1;
               err  = lcfp_pkg::ERR_CMD;
            end else begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (rx_byte != (is_led ? lcfp_pkg::LEN_LED : lcfp_pkg::LEN_OTHER)) begin
               emit = 1'b1;
               err  = lcfp_pkg::ERR_LEN;
            end else begin
               state_in = ST_DATA1;
            end
         end
         ST_DATA1: begin
            if (rx_byte != (is_led ? lcfp_pkg::DATA_ZERO : lcfp_pkg::DATA_ONE)) begin
               emit = 1'b1;
               err  = lcfp_pkg::ERR_DATA1;
            end else if (!is_led) begin
               emit = 1'b1;
               if (cmd_ff == lcfp_pkg::CMD_BLINK) begin
                  led_in = lcfp_pkg::LED_FLASH;
               end
            end else begin
               state_in = ST_DATA2;
            end
         end
         ST_DATA2: begin
            emit = 1'b1;
            if (rx_byte != lcfp_pkg::DATA_ZERO && rx_byte != lcfp_pkg::DATA_ONE) begin
               err = lcfp_pkg::ERR_DATA2;
            end else begin
               led_in = rx_byte[0] ? lcfp_pkg::LED_ON : lcfp_pkg::LED_OFF;
            end
         end
         default: begin
            if (rx_byte != sync_value) begin
               emit = 1'b1;
               err  = lcfp_pkg::ERR_SYNC;
            end else begin
               state_in = ST_CMD;
            end
         end
      endcase
      if (emit) begin
         state_in = ST_SYNC;
         cmd_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC;
         cmd_ff   <= '0;
         led_ff   <= lcfp_pkg::LED_OFF;
      end else if (accept) begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         led_ff   <= led_in;
      end
   end

   assign push.valid          = accept && emit;
   assign push.job.command    = job_cmd;
   assign push.job.led_mode   = led_in;
   assign push.job.error_kind = err;

endmodule

>>> rtl/core/lcfp_queue.sv
// Short job queue between the parser and the reply serializer.
module lcfp_queue #(
   parameter int DEPTH = lcfp_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lcfp_pkg::job_push_type push,
   input  logic                   pop,
   output logic                   full,
   output lcfp_pkg::job_head_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcfp_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign head.empty = (count_ff == '0);
   assign head.job   = slots_ff[rd_ptr_ff];

endmodule

>>> rtl/core/lcfp_back.sv
// Reply serializer: turns one queued job into four reply bytes.
module lcfp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lcfp_pkg::job_head_type head,
   output logic                   head_pop,
   input  logic [7:0]             reply_header,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_byte,
   output logic [1:0]             rsp_led_mode,
   output logic [2:0]             rsp_error_kind
);

   lcfp_pkg::job_type job_ff;
   logic              busy_ff, busy_in;
   logic [1:0]        idx_ff, idx_in;
   logic              taken;
   logic              finish;
   logic              load;

   assign taken    = rsp_pop && busy_ff;
   assign finish   = taken && (idx_ff == lcfp_pkg::IDX_STATUS);
   assign load     = !head.empty && (!busy_ff || finish);
   assign head_pop = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (taken) begin
         idx_in = idx_ff + 1'b1;
      end
      if (load) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= lcfp_pkg::IDX_HEADER;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= head.job;
      end
   end

   always_comb begin
      unique case (idx_ff)
         lcfp_pkg::IDX_HEADER: rsp_tx_byte = reply_header;
         lcfp_pkg::IDX_CMD:    rsp_tx_byte = job_ff.command;
         lcfp_pkg::IDX_TAG:    rsp_tx_byte = lcfp_pkg::REPLY_TAG;
         default: begin
            rsp_tx_byte = (job_ff.error_kind == lcfp_pkg::ERR_NONE) ?
                          lcfp_pkg::STATUS_OK : lcfp_pkg::STATUS_ERR;
         end
      endcase
   end

   assign rsp_empty      = !busy_ff;
   assign rsp_last_byte  = (idx_ff == lcfp_pkg::IDX_STATUS);
   assign rsp_led_mode   = job_ff.led_mode;
   assign rsp_error_kind = job_ff.error_kind;

endmodule

>>> rtl/core/led_command_frame_parser_core.sv
// Top level of the LED command frame parser.
//
// Input queue port: drive req_rx_byte with req_push; a byte is taken at a clock
// edge where req_push is high and req_full is low. Each byte is parsed at once.
// A byte that fails a check, or that completes a frame, yields one reply of four
// items: header, command, 0x01, status. Bytes that complete nothing yield none.
// Result queue port: the oldest item sits on rsp_* while rsp_empty is low and
// is taken at an edge with rsp_pop high. rsp_last_byte marks the status item.
// A due job is written into the job queue, then loaded into the serializer.
// Throughput: the parser takes one byte per cycle while req_full is low;
// replies drain at one item per cycle while rsp_pop is high, with no gap
// between replies while further jobs wait in the queue. One reply sits in the
// serializer and up to QUEUE_DEPTH more wait in the job queue; req_full rises
// when that queue is full, so a stalled receiver back-pressures the sender
// after QUEUE_DEPTH + 1 pending replies.
// Reset (synchronous, active high) empties the queue, returns the parser to
// sync hunt, clears the held command, turns the LED off and restores the
// registers (sync 0xAA at address 0, reply header 0xBB at address 4).
module led_command_frame_parser_core #(
   parameter int QUEUE_DEPTH = lcfp_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_last_byte,
   output logic [1:0]                      rsp_led_mode,
   output logic [2:0]                      rsp_error_kind,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lcfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lcfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lcfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic                   [7:0] sync_value;
   logic                   [7:0] reply_header;
   logic                         accept;
   lcfp_pkg::job_push_type       push;
   lcfp_pkg::job_head_type       head;
   logic                         head_pop;

   assign accept = req_push && !req_full;

   lcfp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .sync_value   (sync_value),
      .reply_header (reply_header)
   );

   lcfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .sync_value (sync_value),
      .push       (push)
   );

   lcfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (head_pop),
      .full  (req_full),
      .head  (head)
   );

   lcfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_pop       (head_pop),
      .reply_header   (reply_header),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_led_mode   (rsp_led_mode),
      .rsp_error_kind (rsp_error_kind)
   );

endmodule

>>> rtl/core/lcfp_checker.sv
// Port-level checks for the LED command frame parser, bound to the top level.
module lcfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_byte,
   input logic [2:0] rsp_error_kind
);

   // a waiting item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_tx_byte))
      else $error("reply item changed while stalled");

   // a reply never breaks off in the middle
   a_reply_whole: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last_byte |=> !rsp_empty)
      else $error("reply broke off before its last item");

   // the status byte agrees with the error kind
   a_status: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_byte |->
         (rsp_error_kind == lcfp_pkg::ERR_NONE && rsp_tx_byte == lcfp_pkg::STATUS_OK) ||
         (rsp_error_kind != lcfp_pkg::ERR_NONE && rsp_tx_byte == lcfp_pkg::STATUS_ERR))
      else $error("status byte disagrees with error kind");

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("reply item present after reset");

endmodule

bind led_command_frame_parser_core lcfp_checker u_lcfp_checker (.*);

>>> test/tb_led_command_frame_parser_core.sv
// Self-checking testbench for the LED command frame parser: byte stream in, reply items out.
module tb_led_command_frame_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int BYTES_PER_PASS = 95;
   localparam int SETTLE_CYCLES  = 4;
   localparam int CSR_AW         = lcfp_pkg::CSR_ADDR_W;
   localparam int CSR_DW         = lcfp_pkg::CSR_DATA_W;

   typedef enum logic [4:0] {
      HUNT_SYNC = 5'b00001,
      GET_CMD   = 5'b00010,
      GET_LEN   = 5'b00100,
      GET_DATA1 = 5'b01000,
      GET_DATA2 = 5'b10000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] tx;
      logic       last;
      logic [1:0] led;
      logic [2:0] err;
   } reply_item_type;

   class frame_scoreboard;
      logic [7:0]      sync_val   = lcfp_pkg::SYNC_RESET;
      logic [7:0]      header_val = lcfp_pkg::HEADER_RESET;
      parse_phase_type phase      = HUNT_SYNC;
      logic [7:0]      cmd_held   = 8'h00;
      logic [1:0]      len_held   = 2'd0;
      logic [1:0]      led_now    = lcfp_pkg::LED_OFF;
      int              errors     = 0;
      reply_item_type  reply_q[$];

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function int pending();
         return reply_q.size();
      endfunction

      function void write_reg(logic idx, logic [7:0] val);
         if (idx == lcfp_pkg::REG_SYNC) begin
            sync_val = val;
         end else begin
            header_val = val;
         end
      endfunction

      function void queue_reply(logic [2:0] err);
         logic [7:0]     bytes [4];
         reply_item_type item;
         bytes[lcfp_pkg::IDX_HEADER] = header_val;
         bytes[lcfp_pkg::IDX_CMD]    = cmd_held;
         bytes[lcfp_pkg::IDX_TAG]    = lcfp_pkg::REPLY_TAG;
         bytes[lcfp_pkg::IDX_STATUS] = (err == lcfp_pkg::ERR_NONE) ?
                                       lcfp_pkg::STATUS_OK : lcfp_pkg::STATUS_ERR;
         for (int k = 0; k < 4; k++) begin
            item.tx   = bytes[k];
            item.last = (k == lcfp_pkg::IDX_STATUS);
            item.led  = led_now;
            item.err  = err;
            reply_q.push_back(item);
         end
         phase    = HUNT_SYNC;
         cmd_held = 8'h00;
         len_held = 2'd0;
      endfunction

      // called for every accepted rx byte
      function void note_byte(logic [7:0] b);
         unique case (phase)
            GET_CMD: begin
               cmd_held = b;
               if (b != lcfp_pkg::CMD_LED && b != lcfp_pkg::CMD_BLINK &&
                   b != lcfp_pkg::CMD_QUERY) begin
                  queue_reply(lcfp_pkg::ERR_CMD);
               end else begin
                  phase = GET_LEN;
               end
            end
            GET_LEN: begin
               if (b != ((cmd_held == lcfp_pkg::CMD_LED) ?
                         lcfp_pkg::LEN_LED : lcfp_pkg::LEN_OTHER)) begin
                  queue_reply(lcfp_pkg::ERR_LEN);
               end else begin
                  len_held = b[1:0];
                  phase    = GET_DATA1;
               end
            end
            GET_DATA1: begin
               if (b != ((cmd_held == lcfp_pkg::CMD_LED) ?
                         lcfp_pkg::DATA_ZERO : lcfp_pkg::DATA_ONE)) begin
                  queue_reply(lcfp_pkg::ERR_DATA1);
               end else if (len_held == 2'd1) begin
                  if (cmd_held == lcfp_pkg::CMD_BLINK) led_now = lcfp_pkg::LED_FLASH;
                  queue_reply(lcfp_pkg::ERR_NONE);
               end else begin
                  phase = GET_DATA2;
               end
            end
            GET_DATA2: begin
               if (b != lcfp_pkg::DATA_ZERO && b != lcfp_pkg::DATA_ONE) begin
                  queue_reply(lcfp_pkg::ERR_DATA2);
               end else begin
                  led_now = (b == lcfp_pkg::DATA_ONE) ? lcfp_pkg::LED_ON : lcfp_pkg::LED_OFF;
                  queue_reply(lcfp_pkg::ERR_NONE);
               end
            end
            default: begin
               if (b != sync_val) begin
                  queue_reply(lcfp_pkg::ERR_SYNC);
               end else begin
                  phase = GET_CMD;
               end
            end
         endcase
      endfunction

      task check(logic [7:0] tx, logic last, logic [1:0] led, logic [2:0] err);
         reply_item_type want;
         if (reply_q.size() == 0) begin
            report($sformatf("item with nothing expected: tx=%h last=%b led=%0d err=%0d",
                             tx, last, led, err));
            return;
         end
         want = reply_q.pop_front();
         if (tx !== want.tx)
            report($sformatf("tx_byte %h, expected %h", tx, want.tx));
         if (last !== want.last)
            report($sformatf("last_byte %b, expected %b (tx %h)", last, want.last, want.tx));
         if (led !== want.led)
            report($sformatf("led_mode %0d, expected %0d (tx %h)", led, want.led, want.tx));
         if (err !== want.err)
            report($sformatf("error_kind %0d, expected %0d (tx %h)", err, want.err, want.tx));
      endtask
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_push       = 1'b0;
   logic              req_full;
   logic [7:0]        req_rx_byte    = 8'h00;
   logic              rsp_empty;
   logic              rsp_pop        = 1'b0;
   logic [7:0]        rsp_tx_byte;
   logic              rsp_last_byte;
   logic [1:0]        rsp_led_mode;
   logic [2:0]        rsp_error_kind;
   logic              csr_psel       = 1'b0;
   logic              csr_penable    = 1'b0;
   logic              csr_pwrite     = 1'b0;
   logic [CSR_AW-1:0] csr_paddr      = '0;
   logic [CSR_DW-1:0] csr_pwdata     = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   frame_scoreboard sb = new();
   int              send_idle_pct = 0;
   int              stall_pct     = 0;
   int              bytes_sent    = 0;
   int              cycle_count   = 0;

   led_command_frame_parser_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_rx_byte   (req_rx_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .rsp_led_mode  (rsp_led_mode),
      .rsp_error_kind(rsp_error_kind),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_push && !req_full) sb.note_byte(req_rx_byte);
         if (rsp_pop && !rsp_empty)
            sb.check(rsp_tx_byte, rsp_last_byte, rsp_led_mode, rsp_error_kind);
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count, sb.pending());
         $display("led_command_frame_parser_core test failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   // mostly the intended value, now and then a random byte
   function automatic logic [7:0] corrupt(input logic [7:0] good);
      if ($urandom_range(99) < 12) return 8'($urandom_range(255));
      return good;
   endfunction

   task automatic send_frame();
      logic [7:0] cmd;
      logic [7:0] b;
      int         pick;
      if ($urandom_range(99) < 12) begin
         send_byte(8'($urandom_range(255)));
         return;
      end
      send_byte(sb.sync_val);
      pick = $urandom_range(99);
      if (pick < 40)      cmd = lcfp_pkg::CMD_LED;
      else if (pick < 65) cmd = lcfp_pkg::CMD_BLINK;
      else if (pick < 90) cmd = lcfp_pkg::CMD_QUERY;
      else                cmd = 8'($urandom_range(255));
      send_byte(cmd);
      if (cmd != lcfp_pkg::CMD_LED && cmd != lcfp_pkg::CMD_BLINK &&
          cmd != lcfp_pkg::CMD_QUERY) return;
      b = corrupt((cmd == lcfp_pkg::CMD_LED) ? lcfp_pkg::LEN_LED : lcfp_pkg::LEN_OTHER);
      send_byte(b);
      if (b != ((cmd == lcfp_pkg::CMD_LED) ? lcfp_pkg::LEN_LED : lcfp_pkg::LEN_OTHER)) return;
      b = corrupt((cmd == lcfp_pkg::CMD_LED) ? lcfp_pkg::DATA_ZERO : lcfp_pkg::DATA_ONE);
      send_byte(b);
      if (b != ((cmd == lcfp_pkg::CMD_LED) ? lcfp_pkg::DATA_ZERO : lcfp_pkg::DATA_ONE) ||
          cmd != lcfp_pkg::CMD_LED) return;
      send_byte(corrupt(8'($urandom_range(1))));
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] val);
      logic [CSR_DW-1:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DW'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      // read back
      csr_psel  <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (rd[7:0] !== val)
         sb.report($sformatf("register %0d reads %h, wrote %h", idx, rd, val));
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_pass(input int send_pct, input int recv_pct);
      int stop_at;
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      stop_at       = bytes_sent + BYTES_PER_PASS;
      while (bytes_sent < stop_at) send_frame();
      req_push <= 1'b0;
      @(posedge clock);
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bad sync, each command, and the command, length and second data byte errors
      send_byte(8'h00);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(lcfp_pkg::CMD_LED);
      send_byte(lcfp_pkg::LEN_LED);
      send_byte(lcfp_pkg::DATA_ZERO); send_byte(lcfp_pkg::DATA_ONE);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(lcfp_pkg::CMD_QUERY);
      send_byte(lcfp_pkg::LEN_OTHER); send_byte(lcfp_pkg::DATA_ONE);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(lcfp_pkg::CMD_BLINK);
      send_byte(lcfp_pkg::LEN_OTHER); send_byte(lcfp_pkg::DATA_ONE);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(8'hFF);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(lcfp_pkg::CMD_BLINK);
      send_byte(lcfp_pkg::LEN_LED);
      send_byte(lcfp_pkg::SYNC_RESET); send_byte(lcfp_pkg::CMD_LED);
      send_byte(lcfp_pkg::LEN_LED);
      send_byte(lcfp_pkg::DATA_ZERO); send_byte(8'h80);
      req_push <= 1'b0;
      @(posedge clock);
      drain();

      run_pass(0, 0);
      csr_write(lcfp_pkg::REG_SYNC, 8'h00);
      csr_write(lcfp_pkg::REG_HEADER, 8'hFF);
      run_pass(58, 0);
      csr_write(lcfp_pkg::REG_SYNC, 8'hFF);
      csr_write(lcfp_pkg::REG_HEADER, 8'h00);
      run_pass(0, 58);
      csr_write(lcfp_pkg::REG_SYNC, 8'($urandom_range(255)));
      csr_write(lcfp_pkg::REG_HEADER, 8'($urandom_range(255)));
      run_pass(28, 28);
      csr_write(lcfp_pkg::REG_SYNC, lcfp_pkg::SYNC_RESET);
      csr_write(lcfp_pkg::REG_HEADER, lcfp_pkg::HEADER_RESET);
      run_pass(0, 0);

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("led_command_frame_parser_core test passed");
      end else begin
         $display("led_command_frame_parser_core test failed");
      end
      $finish;
   end
endmodule
